FILE: rtl/burst_energy_detector_top_defines.svh
// Assertion macros for the burst energy detector
`ifndef BURST_ENERGY_DETECTOR_TOP_DEFINES_SVH
`define BURST_ENERGY_DETECTOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle
`define BED_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the next cycle
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bed_pkg.sv
package bed_pkg;

  // Window geometry; the dB offset of the mean assumes a power-of-two window
  localparam int unsigned WINDOW = 1024;
  localparam int unsigned POS_W  = $clog2(WINDOW);
  localparam int unsigned HOP_W  = POS_W + 1;
  localparam int unsigned PWR_W  = 32;
  localparam int unsigned SUM_W  = PWR_W + POS_W;
  localparam int unsigned P_W    = $clog2(SUM_W);
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned MANT_W = 31;
  localparam int unsigned L_W    = P_W + FRAC_W + 1;
  localparam int unsigned PROD_W = 42;
  localparam int unsigned SAT_W  = 42;
  localparam int unsigned DB_W   = 16;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned NCNT_W = 17;
  localparam int unsigned NACC_W = 33;
  localparam int unsigned K_MAX  = 16;

  localparam logic signed [L_W-1:0]  LOG2W_Q16   = L_W'(POS_W * 65536);
  localparam logic signed [19:0]     DB_PER_LOG2 = 20'sd197283;
  localparam logic signed [PROD_W-1:0] DB_ROUND  = PROD_W'(64'd8388608);
  localparam logic signed [DB_W-1:0] DB_MIN = 16'sh8000;
  localparam logic signed [DB_W-1:0] DB_MAX = 16'sh7fff;

  typedef enum logic [1:0] {
    CFG_MARGIN = 2'd0,
    CFG_NWIN   = 2'd1,
    CFG_MIN    = 2'd2,
    CFG_MAX    = 2'd3
  } cfg_idx_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 3'd0,
    EV_WIN   = 3'd1,
    EV_FLOOR = 3'd2,
    EV_START = 3'd3,
    EV_END   = 3'd4,
    EV_ABORT = 3'd5
  } ev_e;

  typedef enum logic [1:0] {
    MODE_MEASURE = 2'd0,
    MODE_SEARCH  = 2'd1,
    MODE_FRAME   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_NORM, ST_SQR, ST_MUL, ST_DB, ST_DECIDE, ST_THR, ST_EMIT
  } state_e;

  // One classified sample as it travels from front to back
  typedef struct packed {
    logic signed [SMP_W-1:0] smp_i;
    logic signed [SMP_W-1:0] smp_q;
    logic                    bend;
    logic [PWR_W-1:0]        power;
  } item_t;

  // Clamp a wide signed value to Q8.8 dB range
  function automatic logic signed [DB_W-1:0] sat_db(input logic signed [SAT_W-1:0] v);
    logic signed [DB_W-1:0] r;
    if (v < SAT_W'(DB_MIN)) begin
      r = DB_MIN;
    end else if (v > SAT_W'(DB_MAX)) begin
      r = DB_MAX;
    end else begin
      r = v[DB_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/bed_front.sv
module bed_front
  import bed_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SMP_W-1:0] smp_i_i,
  input  logic signed [SMP_W-1:0] smp_q_i,
  input  logic                    bend_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output item_t                   push_item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;
  logic signed [2*SMP_W-1:0] sq_i, sq_q;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  // Instantaneous power of the sample
  assign sq_i = smp_i_i * smp_i_i;
  assign sq_q = smp_q_i * smp_q_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the classified sample until the queue takes it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.smp_i <= smp_i_i;
      item_q.smp_q <= smp_q_i;
      item_q.bend  <= bend_i;
      item_q.power <= PWR_W'(unsigned'(sq_i)) + PWR_W'(unsigned'(sq_q));
    end
  end

endmodule

FILE: rtl/bed_fifo.sv
module bed_fifo
  import bed_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/bed_back.sv
module bed_back
  import bed_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  cfg_idx_e               cfg_idx_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  item_t                  pop_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ev_e                    out_ev_o,
  output logic signed [DB_W-1:0] out_pw_o,
  output logic signed [DB_W-1:0] out_thr_o,
  output logic                   out_inf_o,
  output logic signed [SMP_W-1:0] out_i_o,
  output logic signed [SMP_W-1:0] out_q_o
);

  // Configuration
  logic [14:0] margin_q;
  logic [4:0]  nwin_q;
  logic [31:0] min_q, max_q;

  // Control state
  state_e st_q, st_d;
  mode_e  mode_q, mode_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              full_q, full_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [HOP_W-1:0]  hop_q, hop_d;
  logic [NCNT_W-1:0] ncnt_q, ncnt_d;
  logic signed [NACC_W-1:0] nacc_q, nacc_d;
  logic signed [DB_W-1:0]   floor_q, floor_d;
  logic signed [DB_W-1:0]   thr_q, thr_d;
  logic [31:0]       fcnt_q, fcnt_d;
  logic              out_v_q, out_v_d;

  // Datapath registers
  item_t            item_q, item_d;
  logic [SUM_W-1:0] m_q, m_d;
  logic [P_W-1:0]   p_q, p_d;
  logic [MANT_W-1:0] mant_q, mant_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [3:0]       it_q, it_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DB_W-1:0]   pw_q, pw_d;
  ev_e              ev_q, ev_d;
  logic             inf_q, inf_d;
  ev_e              oev_q, oev_d;
  logic signed [DB_W-1:0]  opw_q, opw_d, othr_q, othr_d;
  logic             oinf_q, oinf_d;
  logic signed [SMP_W-1:0] oi_q, oi_d, oq_q, oq_d;

  // Power ring
  logic [PWR_W-1:0] ring [WINDOW];
  logic [PWR_W-1:0] rd_q;
  logic             ring_we;

  // Combinational helpers
  logic [PWR_W-1:0]   old_pwr;
  logic               eval;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]    t;
  logic signed [L_W-1:0] l;
  logic [4:0]         kc;
  logic signed [NACC_W-1:0] acc_new;
  logic [NCNT_W-1:0]  cnt_new;
  logic [31:0]        cnt_inc;
  logic [HOP_W-1:0]   hop_inc;

  assign pop_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_ev_o    = oev_q;
  assign out_pw_o    = opw_q;
  assign out_thr_o   = othr_q;
  assign out_inf_o   = oinf_q;
  assign out_i_o     = oi_q;
  assign out_q_o     = oq_q;

  assign old_pwr = full_q ? rd_q : '0;
  assign sq      = mant_q * mant_q;
  assign t       = sq[2*MANT_W-1 -: MANT_W+1];
  assign l       = signed'({1'b0, p_q, frac_q}) - LOG2W_Q16;
  assign kc      = (nwin_q > 5'(K_MAX)) ? 5'(K_MAX) : nwin_q;
  assign acc_new = nacc_q + NACC_W'(pw_q);
  assign cnt_new = ncnt_q + 1'b1;
  assign cnt_inc = (fcnt_q == '1) ? fcnt_q : fcnt_q + 1'b1;
  assign hop_inc = hop_q + 1'b1;

  // Decide whether this sample closes a window that must be evaluated
  always_comb begin
    unique case (mode_q)
      MODE_MEASURE: eval = (hop_inc >= HOP_W'(WINDOW));
      MODE_SEARCH:  eval = (hop_inc >= HOP_W'(WINDOW / 2));
      MODE_FRAME:   eval = item_q.bend;
      default:      eval = 1'b0;
    endcase
  end

  always_comb begin
    st_d    = st_q;
    mode_d  = mode_q;
    pos_d   = pos_q;
    full_d  = full_q;
    sum_d   = sum_q;
    hop_d   = hop_q;
    ncnt_d  = ncnt_q;
    nacc_d  = nacc_q;
    floor_d = floor_q;
    thr_d   = thr_q;
    fcnt_d  = fcnt_q;
    out_v_d = out_v_q;
    item_d  = item_q;
    m_d     = m_q;
    p_d     = p_q;
    mant_d  = mant_q;
    frac_d  = frac_q;
    it_d    = it_q;
    prod_d  = prod_q;
    pw_d    = pw_q;
    ev_d    = ev_q;
    inf_d   = inf_q;
    oev_d   = oev_q;
    opw_d   = opw_q;
    othr_d  = othr_q;
    oinf_d  = oinf_q;
    oi_d    = oi_q;
    oq_d    = oq_q;
    ring_we = 1'b0;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          item_d = pop_item_i;
          st_d   = ST_SUM;
        end
      end
      // Slide the window and store the new power
      ST_SUM: begin
        sum_d   = sum_q - SUM_W'(old_pwr) + SUM_W'(item_q.power);
        ring_we = 1'b1;
        if (pos_q == POS_W'(WINDOW - 1)) begin
          pos_d  = '0;
          full_d = 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
        if (!eval) begin
          pw_d = '0;
          st_d = ST_DECIDE;
        end else if (sum_d == '0) begin
          pw_d = DB_MIN;
          st_d = ST_DECIDE;
        end else begin
          m_d  = sum_d;
          p_d  = P_W'(SUM_W - 1);
          st_d = ST_NORM;
        end
      end
      // Find the top set bit, one position per cycle
      ST_NORM: begin
        if (m_q[SUM_W-1]) begin
          mant_d = m_q[SUM_W-1 -: MANT_W];
          frac_d = '0;
          it_d   = '0;
          st_d   = ST_SQR;
        end else begin
          m_d = m_q << 1;
          p_d = p_q - 1'b1;
        end
      end
      // One fraction bit of log2 per squaring
      ST_SQR: begin
        frac_d = {frac_q[FRAC_W-2:0], t[MANT_W]};
        mant_d = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        it_d   = it_q + 1'b1;
        if (it_q == 4'(FRAC_W - 1)) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = l * DB_PER_LOG2 + DB_ROUND;
        st_d   = ST_DB;
      end
      ST_DB: begin
        pw_d = sat_db(SAT_W'(prod_q >>> 24));
        st_d = ST_DECIDE;
      end
      // Apply the detector state machine for this sample
      ST_DECIDE: begin
        ev_d  = EV_NONE;
        inf_d = 1'b0;
        st_d  = ST_EMIT;
        unique case (mode_q)
          MODE_MEASURE: begin
            hop_d = hop_inc;
            if (eval) begin
              hop_d  = '0;
              nacc_d = acc_new;
              ncnt_d = cnt_new;
              ev_d   = EV_WIN;
              if (cnt_new >= (NCNT_W'(1) << kc)) begin
                floor_d = sat_db(SAT_W'(acc_new >>> kc));
                nacc_d  = '0;
                ncnt_d  = '0;
                mode_d  = MODE_SEARCH;
                ev_d    = EV_FLOOR;
                st_d    = ST_THR;
              end
            end
          end
          MODE_SEARCH: begin
            hop_d = hop_inc;
            if (eval) begin
              hop_d = '0;
              ev_d  = EV_WIN;
              if (pw_q >= thr_q) begin
                mode_d = MODE_FRAME;
                fcnt_d = 32'(WINDOW);
                ev_d   = EV_START;
                inf_d  = 1'b1;
              end
            end
          end
          MODE_FRAME: begin
            inf_d  = 1'b1;
            fcnt_d = cnt_inc;
            if (item_q.bend) begin
              ev_d = EV_WIN;
              if (cnt_inc > max_q) begin
                ev_d   = EV_ABORT;
                fcnt_d = '0;
                mode_d = MODE_MEASURE;
                hop_d  = '0;
                ncnt_d = '0;
                nacc_d = '0;
              end else if (cnt_inc > min_q && pw_q < thr_q) begin
                ev_d   = EV_END;
                fcnt_d = '0;
                mode_d = MODE_SEARCH;
                hop_d  = '0;
              end
            end
          end
          default: begin
            mode_d = MODE_MEASURE;
            hop_d  = '0;
            ncnt_d = '0;
            nacc_d = '0;
          end
        endcase
      end
      ST_THR: begin
        thr_d = sat_db(SAT_W'(floor_q) + SAT_W'(margin_q));
        st_d  = ST_EMIT;
      end
      // Load the output register once it is free
      ST_EMIT: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          oev_d   = ev_q;
          opw_d   = pw_q;
          othr_d  = thr_q;
          oinf_d  = inf_q;
          oi_d    = item_q.smp_i;
          oq_d    = item_q.smp_q;
          st_d    = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // Margin write recomputes the threshold from the stored floor
    if (cfg_we_i && cfg_idx_i == CFG_MARGIN) begin
      thr_d = sat_db(SAT_W'(floor_q) + SAT_W'(cfg_data_i[14:0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      mode_q   <= MODE_MEASURE;
      pos_q    <= '0;
      full_q   <= 1'b0;
      sum_q    <= '0;
      hop_q    <= '0;
      ncnt_q   <= '0;
      nacc_q   <= '0;
      floor_q  <= '0;
      thr_q    <= '0;
      fcnt_q   <= '0;
      out_v_q  <= 1'b0;
      margin_q <= 15'd2560;
      nwin_q   <= 5'd10;
      min_q    <= 32'd65536;
      max_q    <= 32'd16777216;
    end else begin
      st_q    <= st_d;
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      full_q  <= full_d;
      sum_q   <= sum_d;
      hop_q   <= hop_d;
      ncnt_q  <= ncnt_d;
      nacc_q  <= nacc_d;
      floor_q <= floor_d;
      thr_q   <= thr_d;
      fcnt_q  <= fcnt_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MARGIN: margin_q <= cfg_data_i[14:0];
          CFG_NWIN:   nwin_q   <= cfg_data_i[4:0];
          CFG_MIN:    min_q    <= cfg_data_i;
          CFG_MAX:    max_q    <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    m_q    <= m_d;
    p_q    <= p_d;
    mant_q <= mant_d;
    frac_q <= frac_d;
    it_q   <= it_d;
    prod_q <= prod_d;
    pw_q   <= pw_d;
    ev_q   <= ev_d;
    inf_q  <= inf_d;
    oev_q  <= oev_d;
    opw_q  <= opw_d;
    othr_q <= othr_d;
    oinf_q <= oinf_d;
    oi_q   <= oi_d;
    oq_q   <= oq_d;
  end

  // Ring memory; entries not yet written read as zero through full_q
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[pos_q] <= item_q.power;
    end
    rd_q <= ring[pos_q];
  end

endmodule

FILE: rtl/burst_energy_detector_top.sv
// Each sample passes the front register, a two-entry queue and the back stage; an
// evaluated window adds a bit-serial normalize, 16 log2 squarings and a dB multiply.
// The back stage takes a new sample only once it has emitted the last; its bit-serial
// normalize and log2 steps and output back-pressure set the rate.
// Reset: asynchronous, active low; clears the detector to noise measurement and the
// power ring reads as zero until filled once; no clearing pass is needed.
`include "burst_energy_detector_top_defines.svh"

module burst_energy_detector_top
  import bed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_i, sample_q
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // power_db, threshold_db, out_i, out_q
  output logic [3:0]  m_axis_tuser    // event_code, in_frame
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;
  ev_e   out_ev;
  logic signed [DB_W-1:0]  out_pw, out_thr;
  logic  out_inf;
  logic signed [SMP_W-1:0] out_i, out_q;

  bed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .smp_i_i      (s_axis_tdata[15:0]),
    .smp_q_i      (s_axis_tdata[31:16]),
    .bend_i       (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  bed_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  bed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ev_o    (out_ev),
    .out_pw_o    (out_pw),
    .out_thr_o   (out_thr),
    .out_inf_o   (out_inf),
    .out_i_o     (out_i),
    .out_q_o     (out_q)
  );

  assign m_axis_tdata = {out_q, out_i, out_thr, out_pw};
  assign m_axis_tuser = {out_inf, out_ev};

  `BED_ASSERT_SAME(a_none_has_zero_db, m_axis_tvalid && out_ev == EV_NONE, out_pw == '0, "event none carries nonzero power")
  `BED_ASSERT_SAME(a_start_in_frame, m_axis_tvalid && out_ev == EV_START, out_inf, "frame start without in_frame")
  `BED_ASSERT_SAME(a_floor_not_in_frame, m_axis_tvalid && out_ev == EV_FLOOR, !out_inf, "floor set inside a frame")
  `BED_ASSERT_NEXT(a_push_keeps_queue, push_valid && push_ready && !pop_ready, pop_valid, "queue lost a transaction")

endmodule
